// File: rtl/rtbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbt_pkg
// Types, register map, event codes and sizing constants shared by the
// rate trigger ban table block.
// ----------------------------------------------------------------------------
package rtbt_pkg;

    localparam int BAN_ENTRIES_DEF = 16;
    localparam int MAX_OUT         = 16;
    localparam int CMD_DEPTH       = 4;
    localparam int OUT_DEPTH       = 2;
    localparam int ADDR_W          = 5;
    localparam int REG_IDX_W       = 3;
    localparam int DATA_W          = 32;

    localparam logic [REG_IDX_W-1:0] REG_RULE_PROTOCOL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYN_ONLY       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PPS_LIMIT      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MBPS_LIMIT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MBPS_CEILING   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FLOW_COUNT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_SOURCE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BAN_TICKS      = 3'd7;

    localparam logic [1:0] EV_BAN_ADD    = 2'd0;
    localparam logic [1:0] EV_BAN_EXPIRE = 2'd1;
    localparam logic [1:0] EV_BAN_DROP   = 2'd2;

    localparam logic [7:0]  SYN_FLAG      = 8'h02;
    localparam logic [39:0] BITS_PER_MBIT = 40'd1000000;

    typedef struct packed {
        logic [7:0]  rule_protocol;
        logic        syn_only;
        logic [31:0] pps_limit;
        logic [19:0] mbps_limit;
        logic [19:0] mbps_ceiling;
        logic [31:0] min_flow_count;
        logic        match_source;
        logic [19:0] ban_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rule_protocol:  8'd6,
        syn_only:       1'b0,
        pps_limit:      32'd0,
        mbps_limit:     20'd0,
        mbps_ceiling:   20'd0,
        min_flow_count: 32'd0,
        match_source:   1'b0,
        ban_ticks:      20'd300
    };

    // Work handed from the classifier to the table engine
    typedef struct packed {
        logic        is_tick;
        logic [31:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] address;
        logic        last;
    } res_t;

endpackage

// File: rtl/rate_trigger_ban_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_trigger_ban_table_core
// Rate rule evaluation with a ban table of countdown entries.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | push / full            | func, ip_proto ... exempt
//   result   | pop / empty            | event_res, address, last
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready = 1)
//
// A packet item is registered and classified in the input stage, and a triggered
// one is applied to the table via the command queue; any result is registered
// in the result queue. A tick holds the engine (take, one per entry, close).
// Reset clears all ban entries at once; no clearing pass is needed.
// Input and result sides stall independently through the command queue
// and the result queue.
// ----------------------------------------------------------------------------
module rate_trigger_ban_table_core
    import rtbt_pkg::*;
#(
    parameter int BAN_ENTRIES = BAN_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic              func,
    input  logic [7:0]        ip_proto,
    input  logic [31:0]       src_addr,
    input  logic [31:0]       dst_addr,
    input  logic [7:0]        flag_bits,
    input  logic [31:0]       packet_rate,
    input  logic [39:0]       bit_rate,
    input  logic [31:0]       flow_count,
    input  logic              flow_known,
    input  logic              exempt,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        event_res,
    output logic [31:0]       address,
    output logic              last
);

    cfg_t cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic cfg_we;

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_empty;

    logic res_push;
    res_t res_in;
    logic res_full;
    res_t res_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx)
                REG_RULE_PROTOCOL:  cfg_next.rule_protocol  = pwdata[7:0];
                REG_SYN_ONLY:       cfg_next.syn_only       = pwdata[0];
                REG_PPS_LIMIT:      cfg_next.pps_limit      = pwdata;
                REG_MBPS_LIMIT:     cfg_next.mbps_limit     = pwdata[19:0];
                REG_MBPS_CEILING:   cfg_next.mbps_ceiling   = pwdata[19:0];
                REG_MIN_FLOW_COUNT: cfg_next.min_flow_count = pwdata;
                REG_MATCH_SOURCE:   cfg_next.match_source   = pwdata[0];
                REG_BAN_TICKS:      cfg_next.ban_ticks      = pwdata[19:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RULE_PROTOCOL:  prdata = {24'd0, cfg_reg.rule_protocol};
            REG_SYN_ONLY:       prdata = {31'd0, cfg_reg.syn_only};
            REG_PPS_LIMIT:      prdata = cfg_reg.pps_limit;
            REG_MBPS_LIMIT:     prdata = {12'd0, cfg_reg.mbps_limit};
            REG_MBPS_CEILING:   prdata = {12'd0, cfg_reg.mbps_ceiling};
            REG_MIN_FLOW_COUNT: prdata = cfg_reg.min_flow_count;
            REG_MATCH_SOURCE:   prdata = {31'd0, cfg_reg.match_source};
            REG_BAN_TICKS:      prdata = {12'd0, cfg_reg.ban_ticks};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rtbt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .func        (func),
        .ip_proto    (ip_proto),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .flag_bits   (flag_bits),
        .packet_rate (packet_rate),
        .bit_rate    (bit_rate),
        .flow_count  (flow_count),
        .flow_known  (flow_known),
        .exempt      (exempt),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .cmd_full    (cmd_full)
    );

    rtbt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    rtbt_back #(
        .BAN_ENTRIES (BAN_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    rtbt_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign event_res = res_out.event_res;
    assign address   = res_out.address;
    assign last      = res_out.last;

endmodule

// File: rtl/rtbt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbt_fifo
// Small flop-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rtbt_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/rtbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbt_front
// Input stage and rule classifier: registers one item, evaluates the rate
// rule and forwards ticks and triggered addresses as commands.
// ----------------------------------------------------------------------------
module rtbt_front
    import rtbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  ip_proto,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  flag_bits,
    input  logic [31:0] packet_rate,
    input  logic [39:0] bit_rate,
    input  logic [31:0] flow_count,
    input  logic        flow_known,
    input  logic        exempt,
    output logic        cmd_push,
    output cmd_t        cmd_data,
    input  logic        cmd_full
);

    logic        stg_valid_reg, stg_valid_next;
    logic        func_reg;
    logic [7:0]  ip_proto_reg;
    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [7:0]  flag_bits_reg;
    logic [31:0] packet_rate_reg;
    logic [39:0] bit_rate_reg;
    logic [31:0] flow_count_reg;
    logic        flow_known_reg;
    logic        exempt_reg;

    // Megabit thresholds scaled to bits: mbps > T  <=>  bits >= (T+1)*1e6
    logic [39:0] thr_above_reg, thr_above_next;
    logic [39:0] thr_low_reg, thr_low_next;
    logic [39:0] thr_below_reg, thr_below_next;
    logic [20:0] target_p1;
    logic [20:0] below_p1;

    logic trig;
    logic match;
    logic need_push;
    logic advance;
    logic accept;

    assign target_p1      = {1'b0, cfg.mbps_limit} + 21'd1;
    assign below_p1       = {1'b0, cfg.mbps_ceiling} + 21'd1;
    assign thr_above_next = {19'd0, target_p1} * BITS_PER_MBIT;
    assign thr_low_next   = {20'd0, cfg.mbps_limit} * BITS_PER_MBIT;
    assign thr_below_next = {19'd0, below_p1} * BITS_PER_MBIT;

    always_comb
    begin
        trig = 1'b0;
        if (cfg.pps_limit != '0 && packet_rate_reg > cfg.pps_limit)
        begin
            trig = 1'b1;
        end
        if (cfg.mbps_limit != '0 && bit_rate_reg >= thr_above_reg)
        begin
            trig = 1'b1;
        end
        if (cfg.mbps_limit != '0 && bit_rate_reg < thr_low_reg)
        begin
            trig = 1'b0;
        end
        if (cfg.mbps_ceiling != '0 && bit_rate_reg >= thr_below_reg)
        begin
            trig = 1'b0;
        end
        if (cfg.syn_only && flag_bits_reg != SYN_FLAG)
        begin
            trig = 1'b0;
        end
        if (cfg.min_flow_count != '0 && flow_count_reg < cfg.min_flow_count)
        begin
            trig = 1'b0;
        end
        if (exempt_reg)
        begin
            trig = 1'b0;
        end
    end

    assign match     = flow_known_reg && (ip_proto_reg == cfg.rule_protocol) && trig;
    assign need_push = func_reg || match;
    assign cmd_push  = stg_valid_reg && need_push && !cmd_full;
    assign advance   = !need_push || !cmd_full;
    assign full      = stg_valid_reg && !advance;
    assign accept    = push && !full;

    always_comb
    begin
        cmd_data.is_tick = func_reg;
        cmd_data.addr    = cfg.match_source ? src_addr_reg : dst_addr_reg;
    end

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
        end
        else if (stg_valid_reg && advance)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thr_above_reg <= thr_above_next;
        thr_low_reg   <= thr_low_next;
        thr_below_reg <= thr_below_next;
        if (accept)
        begin
            func_reg        <= func;
            ip_proto_reg    <= ip_proto;
            src_addr_reg    <= src_addr;
            dst_addr_reg    <= dst_addr;
            flag_bits_reg   <= flag_bits;
            packet_rate_reg <= packet_rate;
            bit_rate_reg    <= bit_rate;
            flow_count_reg  <= flow_count;
            flow_known_reg  <= flow_known;
            exempt_reg      <= exempt;
        end
    end

endmodule

// File: rtl/rtbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbt_back
// Ban table engine: inserts bans with a parallel lookup; each tick sweeps the
// table one entry per cycle unless res_full, counting down and expiring bans.
// ----------------------------------------------------------------------------
module rtbt_back
    import rtbt_pkg::*;
#(
    parameter int BAN_ENTRIES = BAN_ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_empty,
    input  cmd_t cmd_data,
    output logic cmd_pop,
    output logic res_push,
    output res_t res_data,
    input  logic res_full
);

    localparam int IDX_W = (BAN_ENTRIES > 1) ? $clog2(BAN_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_OUT + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [31:0]            hold_addr_reg, hold_addr_next;
    logic [BAN_ENTRIES-1:0] entry_valid_reg, entry_valid_next;
    logic [31:0]            entry_address_reg [BAN_ENTRIES];
    logic [19:0]            entry_remaining_reg [BAN_ENTRIES];

    logic             hit;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             ban_we;
    logic             rem_we;
    logic [19:0]      rem_val;
    logic [19:0]      cur_rem;

    assign cur_rem = entry_remaining_reg[idx_reg];

    // Lowest free entry and address hit over the whole table
    always_comb
    begin
        hit        = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BAN_ENTRIES - 1; i >= 0; i--)
        begin
            if (!entry_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (entry_valid_reg[i] && entry_address_reg[i] == cmd_data.addr)
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        hold_valid_next  = hold_valid_reg;
        hold_addr_next   = hold_addr_reg;
        entry_valid_next = entry_valid_reg;
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        res_data         = '0;
        ban_we           = 1'b0;
        rem_we           = 1'b0;
        rem_val          = cur_rem;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_data.is_tick)
                    begin
                        state_next      = ST_SWEEP;
                        idx_next        = '0;
                        n_next          = '0;
                        hold_valid_next = 1'b0;
                    end
                    else if (!hit)
                    begin
                        res_push         = 1'b1;
                        res_data.address = cmd_data.addr;
                        res_data.last    = 1'b1;
                        if (free_found)
                        begin
                            res_data.event_res         = EV_BAN_ADD;
                            entry_valid_next[free_idx] = 1'b1;
                            ban_we                     = 1'b1;
                        end
                        else
                        begin
                            res_data.event_res = EV_BAN_DROP;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!res_full)
                begin
                    if (entry_valid_reg[idx_reg])
                    begin
                        if (cur_rem[19:1] == '0)
                        begin
                            if (n_reg < CNT_W'(MAX_OUT))
                            begin
                                // Release the previous expiry; keep this one back
                                // until we know whether it is the final result
                                if (hold_valid_reg)
                                begin
                                    res_push           = 1'b1;
                                    res_data.event_res = EV_BAN_EXPIRE;
                                    res_data.address   = hold_addr_reg;
                                    res_data.last      = 1'b0;
                                end
                                hold_valid_next           = 1'b1;
                                hold_addr_next            = entry_address_reg[idx_reg];
                                n_next                    = n_reg + 1'b1;
                                entry_valid_next[idx_reg] = 1'b0;
                            end
                            else
                            begin
                                rem_we  = 1'b1;
                                rem_val = 20'd1;
                            end
                        end
                        else
                        begin
                            rem_we  = 1'b1;
                            rem_val = cur_rem - 20'd1;
                        end
                    end
                    if (idx_reg == IDX_W'(BAN_ENTRIES - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    res_push           = 1'b1;
                    res_data.event_res = EV_BAN_EXPIRE;
                    res_data.address   = hold_addr_reg;
                    res_data.last      = 1'b1;
                    hold_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            n_reg           <= '0;
            hold_valid_reg  <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            n_reg           <= n_next;
            hold_valid_reg  <= hold_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_addr_reg <= hold_addr_next;
        if (ban_we)
        begin
            entry_address_reg[free_idx]   <= cmd_data.addr;
            entry_remaining_reg[free_idx] <= cfg.ban_ticks;
        end
        if (rem_we)
        begin
            entry_remaining_reg[idx_reg] <= rem_val;
        end
    end

endmodule

// File: rtl/rtbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtbt_checker
// Port-level checks on the result queue and the configuration port.
// ----------------------------------------------------------------------------
module rtbt_checker
    import rtbt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              empty,
    input logic              pop,
    input logic [1:0]        event_res,
    input logic [31:0]       address,
    input logic              last
);

    // A waiting result that is not taken stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(event_res) && $stable(address) && $stable(last))
        else $error("waiting result changed");

    // Ban added or dropped is always the only result of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (event_res == EV_BAN_ADD || event_res == EV_BAN_DROP) |-> last)
        else $error("ban result without last");

    // A ban_ticks write reads back masked to 20 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_BAN_TICKS
        |=> paddr[ADDR_W-1:2] != REG_BAN_TICKS || prdata == {12'd0, $past(pwdata[19:0])})
        else $error("ban_ticks readback mismatch");

endmodule

bind rate_trigger_ban_table_core rtbt_checker u_chk (.*);
